/* design/base64_sensor_frame_decoder_core_macros.svh */
// Assertion macros shared by the checker of the sensor frame decoder.
`ifndef BASE64_SENSOR_FRAME_DECODER_CORE_MACROS_SVH
`define BASE64_SENSOR_FRAME_DECODER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define B64_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define B64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame decoder assertion failed");

`endif

/* design/b64sfd_pkg.sv */
// Types, constants and the base64 character decode shared by the decoder modules.
package b64sfd_pkg;

  localparam int LINE_CHARS = 29;
  localparam int MAX_REPEAT = 64;
  localparam int FRAME_BYTES = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [5:0] COUNT_MAX = 6'd63;
  localparam logic [23:0] ADC_OFFSET = 24'h800000;
  localparam logic [15:0] IMU_OFFSET = 16'h8000;

  // One decoded sample with mid-scale offsets already removed.
  typedef struct packed {
    logic signed [23:0] adc_one;
    logic signed [23:0] adc_two;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               gpio_zero;
    logic               gpio_one;
    logic               charging;
  } sample_t;

  // Characters outside the base64 alphabet decode as zero.
  function automatic logic [5:0] sextet(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 6'd62;
    end else if (c == 8'h2F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

/* design/b64sfd_front.sv */
// Front end: character intake, base64 decode, line framing and sequence gap check.
module b64sfd_front #(
  parameter int MAX_REPEAT = b64sfd_pkg::MAX_REPEAT,
  localparam int CntW = $clog2(MAX_REPEAT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_char_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output logic                push_o,
  output b64sfd_pkg::sample_t push_sample_o,
  output logic [CntW-1:0]     push_count_o,
  input  logic                queue_full_i
);

  localparam logic [8:0] MaxRep = 9'(MAX_REPEAT);
  localparam logic [5:0] DataChars = 6'(b64sfd_pkg::LINE_CHARS - 1);
  localparam logic [5:0] LineChars = 6'(b64sfd_pkg::LINE_CHARS);

  logic        gap_fill_enable_q;
  logic [5:0]  char_count_q, char_count_d;
  logic [23:0] acc_q, acc_d;
  logic [7:0]  frame_q [b64sfd_pkg::FRAME_BYTES];
  logic [7:0]  exp_seq_q;
  logic        armed_q;

  logic        accept, is_lf, line_ok, data_pos, wr_en, fwd_gap;
  logic [2:0]  group;
  logic [7:0]  gap;
  logic [8:0]  ext;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign is_lf      = (rx_char_i == b64sfd_pkg::LINE_FEED);
  assign line_ok    = (char_count_q == LineChars);
  assign data_pos   = (char_count_q < DataChars);
  assign group      = char_count_q[4:2];
  assign wr_en      = accept && !is_lf && data_pos && (char_count_q[1:0] == 2'b11);
  assign acc_d      = {acc_q[17:0], b64sfd_pkg::sextet(rx_char_i)};

  always_comb begin
    char_count_d = char_count_q;
    if (char_count_q != b64sfd_pkg::COUNT_MAX) begin
      char_count_d = char_count_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_fill_enable_q <= 1'b1;
      char_count_q      <= '0;
      acc_q             <= '0;
      exp_seq_q         <= '0;
      armed_q           <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gap_fill_enable_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (is_lf) begin
          char_count_q <= '0;
          acc_q        <= '0;
          if (line_ok) begin
            exp_seq_q <= frame_q[7] + 8'd1;
            if (fwd_gap) begin
              armed_q <= 1'b1;
            end
          end
        end else begin
          char_count_q <= char_count_d;
          if (data_pos) begin
            acc_q <= acc_d;
          end
        end
      end
    end
  end

  // Each completed group of four characters lands as three bytes; the
  // third byte of the last group falls past the frame and is dropped.
  for (genvar i = 0; i < b64sfd_pkg::FRAME_BYTES; i++) begin : g_frame
    localparam int Grp = i / 3;
    localparam int Slot = i % 3;
    always_ff @(posedge clk_i) begin
      if (wr_en && group == 3'(Grp)) begin
        frame_q[i] <= acc_d[23 - 8 * Slot -: 8];
      end
    end
  end

  assign gap     = frame_q[7] - exp_seq_q;
  assign fwd_gap = (gap != 8'd0) && !gap[7];
  assign ext     = {1'b0, gap} + 9'd1;

  always_comb begin
    push_count_o = CntW'(1);
    if (fwd_gap && armed_q && gap_fill_enable_q) begin
      push_count_o = (ext > MaxRep) ? MaxRep[CntW-1:0] : ext[CntW-1:0];
    end
  end

  assign push_o = accept && is_lf && line_ok;

  always_comb begin
    push_sample_o.adc_one   = $signed({frame_q[2], frame_q[1], frame_q[0]}
                                      ^ b64sfd_pkg::ADC_OFFSET);
    push_sample_o.adc_two   = $signed({frame_q[5], frame_q[4], frame_q[3]}
                                      ^ b64sfd_pkg::ADC_OFFSET);
    push_sample_o.accel_x   = $signed({frame_q[9], frame_q[8]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.accel_y   = $signed({frame_q[11], frame_q[10]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.accel_z   = $signed({frame_q[13], frame_q[12]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.mag_x     = $signed({frame_q[15], frame_q[14]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.mag_y     = $signed({frame_q[17], frame_q[16]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.mag_z     = $signed({frame_q[19], frame_q[18]} ^ b64sfd_pkg::IMU_OFFSET);
    push_sample_o.gpio_zero = frame_q[6][5];
    push_sample_o.gpio_one  = frame_q[6][6];
    push_sample_o.charging  = frame_q[6][7];
  end

endmodule

/* design/b64sfd_queue.sv */
// Short queue of decoded samples and their copy counts between front and back.
module b64sfd_queue #(
  parameter int MAX_REPEAT = b64sfd_pkg::MAX_REPEAT,
  localparam int CntW = $clog2(MAX_REPEAT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64sfd_pkg::sample_t push_sample_i,
  input  logic [CntW-1:0]     push_count_i,
  output logic                full_o,
  output logic                head_valid_o,
  output b64sfd_pkg::sample_t head_sample_o,
  output logic [CntW-1:0]     head_count_o,
  input  logic                pop_i
);

  localparam int Depth = b64sfd_pkg::QUEUE_DEPTH;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64sfd_pkg::sample_t sample_q [Depth];
  logic [CntW-1:0]     count_q  [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]    fill_q;

  assign full_o        = (fill_q == FillW'(Depth));
  assign head_valid_o  = (fill_q != '0);
  assign head_sample_o = sample_q[rd_ptr_q];
  assign head_count_o  = count_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sample_q[wr_ptr_q] <= push_sample_i;
      count_q[wr_ptr_q]  <= push_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule

/* design/b64sfd_back.sv */
// Back end: output register that sends each queued sample the requested number of times.
module b64sfd_back #(
  parameter int MAX_REPEAT = b64sfd_pkg::MAX_REPEAT,
  localparam int CntW = $clog2(MAX_REPEAT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  b64sfd_pkg::sample_t head_sample_i,
  input  logic [CntW-1:0]     head_count_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64sfd_pkg::sample_t out_sample_o,
  output logic                out_last_o
);

  logic                out_valid_q;
  logic                last_q;
  logic [CntW-1:0]     rem_q;
  b64sfd_pkg::sample_t sample_q;
  logic                taken, repeat_step;

  assign taken       = out_valid_q && !out_stall_i;
  assign pop_o       = head_valid_i && (!out_valid_q || (taken && last_q));
  assign repeat_step = taken && !last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= head_sample_i;
    end
  end

  // rem_q counts the copies not yet taken, the one on the port included.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        rem_q       <= head_count_i;
        last_q      <= (head_count_i == CntW'(1));
      end else if (repeat_step) begin
        rem_q  <= rem_q - CntW'(1);
        last_q <= (rem_q == CntW'(2));
      end else if (taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = sample_q;
  assign out_last_o   = last_q;

endmodule

/* design/base64_sensor_frame_decoder_core.sv */
// One character is taken per cycle while the sample queue has room; a line feed that
// closes a good line queues a sample at that edge.
// The first copy of a sample passes the queue and then the output register;
// a gapped sample goes out 1 to MAX_REPEAT times, one copy per cycle unless stalled.
// Reset clears counters, sequence state, queue and output valid; gap fill is enabled.
module base64_sensor_frame_decoder_core #(
  parameter int MAX_REPEAT = b64sfd_pkg::MAX_REPEAT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_char_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] adc_one_o,
  output logic signed [23:0] adc_two_o,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [15:0] mag_x_o,
  output logic signed [15:0] mag_y_o,
  output logic signed [15:0] mag_z_o,
  output logic               gpio_zero_o,
  output logic               gpio_one_o,
  output logic               charging_o,
  output logic               last_o
);

  localparam int CntW = $clog2(MAX_REPEAT + 1);

  logic                push, full, head_valid, pop;
  b64sfd_pkg::sample_t push_sample, head_sample, out_sample;
  logic [CntW-1:0]     push_count, head_count;

  b64sfd_front #(.MAX_REPEAT(MAX_REPEAT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_char_i     (rx_char_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_o        (push),
    .push_sample_o (push_sample),
    .push_count_o  (push_count),
    .queue_full_i  (full)
  );

  b64sfd_queue #(.MAX_REPEAT(MAX_REPEAT)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_sample_i (push_sample),
    .push_count_i  (push_count),
    .full_o        (full),
    .head_valid_o  (head_valid),
    .head_sample_o (head_sample),
    .head_count_o  (head_count),
    .pop_i         (pop)
  );

  b64sfd_back #(.MAX_REPEAT(MAX_REPEAT)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_sample_i (head_sample),
    .head_count_i  (head_count),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_sample_o  (out_sample),
    .out_last_o    (last_o)
  );

  assign adc_one_o   = out_sample.adc_one;
  assign adc_two_o   = out_sample.adc_two;
  assign accel_x_o   = out_sample.accel_x;
  assign accel_y_o   = out_sample.accel_y;
  assign accel_z_o   = out_sample.accel_z;
  assign mag_x_o     = out_sample.mag_x;
  assign mag_y_o     = out_sample.mag_y;
  assign mag_z_o     = out_sample.mag_z;
  assign gpio_zero_o = out_sample.gpio_zero;
  assign gpio_one_o  = out_sample.gpio_one;
  assign charging_o  = out_sample.charging;

endmodule

/* design/b64sfd_checker.sv */
// Port-level checks of the frame decoder and the bind that attaches them.
`include "base64_sensor_frame_decoder_core_macros.svh"

module b64sfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] adc_one_o,
  input logic signed [15:0] accel_x_o,
  input logic signed [15:0] mag_z_o,
  input logic               charging_o,
  input logic               last_o
);

  // A stalled request stays on the port.
  `B64_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `B64_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                   $stable(adc_one_o) && $stable(mag_z_o) && $stable(last_o))

  // Copies of one sample follow each other with no gap.
  `B64_ASSERT_NEXT(a_repeat_follows, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !last_o, out_valid_o)

  `B64_ASSERT_NEXT(a_repeat_same, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !last_o,
                   adc_one_o == $past(adc_one_o) && accel_x_o == $past(accel_x_o)
                   && charging_o == $past(charging_o))

endmodule

bind base64_sensor_frame_decoder_core b64sfd_checker u_b64sfd_checker (.*);
